@@ rtl/roct_pkg.sv @@
// shared types and constants for the rectangle overlap count table
`default_nettype none
package roct_pkg;

  localparam int IN_COORD_W  = 16;
  localparam int NUM_W       = 11;
  localparam int COUNT_W     = 11;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_QUERY  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [1:0]            kind;
    logic [1:0]            status;
    logic                  has_slot;
    logic [IN_COORD_W-1:0] xl;
    logic [IN_COORD_W-1:0] yl;
    logic [IN_COORD_W-1:0] xh;
    logic [IN_COORD_W-1:0] yh;
    logic [NUM_W-1:0]      num;
  } job_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [1:0]         status;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/roct_fifo.sv @@
// small register queue with push/full and pop/empty sides
`default_nettype none
module roct_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] data_in,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] data_out
);
  import roct_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    cnt;
  logic             wr;
  logic             rd;

  assign full     = (cnt == CW'(QUEUE_DEPTH));
  assign empty    = (cnt == '0);
  assign wr       = push && !full;
  assign rd       = pop && !empty;
  assign data_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr && !rd) begin
        cnt <= cnt + CW'(1);
      end else if (rd && !wr) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= data_in;
    end
  end

endmodule
`default_nettype wire

@@ rtl/roct_front.sv @@
// front end: accepts items, numbers them and classifies range and full cases
`default_nettype none
module roct_front #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [1:0]                           command,
  input  logic [roct_pkg::IN_COORD_W-1:0]      x_low,
  input  logic [roct_pkg::IN_COORD_W-1:0]      y_low,
  input  logic [roct_pkg::IN_COORD_W-1:0]      x_high,
  input  logic [roct_pkg::IN_COORD_W-1:0]      y_high,
  input  logic [roct_pkg::NUM_W-1:0]           item_number,
  output logic                                 q_push,
  input  logic                                 q_full,
  output roct_pkg::job_t                       q_job,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     q_slot
);
  import roct_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [CNT_W-1:0] counter;
  logic             at_end;
  logic             in_range;
  logic [31:0]      num_ext;

  assign full     = q_full;
  assign q_push   = push;
  assign at_end   = (counter == CNT_W'(TABLE_DEPTH));
  assign num_ext  = 32'(item_number);
  assign in_range = (num_ext != 32'd0) && (num_ext <= 32'(TABLE_DEPTH));
  assign q_slot   = counter;

  always_comb begin
    q_job          = '0;
    q_job.kind     = command;
    q_job.has_slot = !at_end;
    q_job.xl       = x_low;
    q_job.yl       = y_low;
    q_job.xh       = x_high;
    q_job.yh       = y_high;
    q_job.num      = item_number;
    q_job.status   = ST_OK;
    if (command == CMD_INSERT && at_end) begin
      q_job.status = ST_FULL;
    end else if (command == CMD_DELETE && !in_range) begin
      q_job.status = ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (push && !q_full && !at_end) begin
      counter <= counter + CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ rtl/roct_back.sv @@
// back end: table memories, slot updates and the query scan
`default_nettype none
module roct_back #(
  parameter int TABLE_DEPTH = 1024,
  parameter int COORD_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             job_valid,
  output logic                             job_pop,
  input  roct_pkg::job_t                   job,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] slot,
  output logic                             res_push,
  input  logic                             res_full,
  output roct_pkg::result_t                res
);
  import roct_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CW    = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
  localparam int RW    = 4 * CW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WRITE = 6'b000010,
    S_DEL   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t             state;
  job_t               cur;
  logic [CNT_W-1:0]   cur_slot;
  logic [AW-1:0]      scan_idx;
  logic [COUNT_W-1:0] count;
  logic               rd_pend;
  logic               rd_valid;
  logic [RW-1:0]      rd_rect;

  logic               valid_mem [TABLE_DEPTH];
  logic [RW-1:0]      rect_mem  [TABLE_DEPTH];

  logic               we;
  logic               rect_we;
  logic               wr_bit;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        del_ext;
  logic [CNT_W-1:0]   last;
  logic [RW-1:0]      q_rect;
  logic [CW-1:0]      s_xl, s_yl, s_xh, s_yh;
  logic [CW-1:0]      mx_x, mn_x, mx_y, mn_y;
  logic               hit;

  assign job_pop    = (state == S_IDLE) && job_valid;
  assign res_push   = (state == S_DONE);
  assign res.count  = count;
  assign res.status = cur.status;

  assign del_ext = 32'(cur.num) - 32'd1;
  assign last    = cur_slot - CNT_W'(1);
  assign q_rect  = {cur.xl[CW-1:0], cur.yl[CW-1:0], cur.xh[CW-1:0], cur.yh[CW-1:0]};

  always_comb begin
    we      = ((state == S_WRITE) && cur.has_slot) || (state == S_DEL);
    wr_bit  = (state == S_WRITE) && (cur.kind == CMD_INSERT);
    rect_we = (state == S_WRITE) && cur.has_slot && (cur.kind == CMD_INSERT);
    wr_addr = (state == S_DEL) ? del_ext[AW-1:0] : cur_slot[AW-1:0];
  end

  // overlap on both axes: max of lows at most min of highs
  always_comb begin
    {s_xl, s_yl, s_xh, s_yh} = rd_rect;
    mx_x = (s_xl > cur.xl[CW-1:0]) ? s_xl : cur.xl[CW-1:0];
    mn_x = (s_xh < cur.xh[CW-1:0]) ? s_xh : cur.xh[CW-1:0];
    mx_y = (s_yl > cur.yl[CW-1:0]) ? s_yl : cur.yl[CW-1:0];
    mn_y = (s_yh < cur.yh[CW-1:0]) ? s_yh : cur.yh[CW-1:0];
    hit  = rd_valid && (mx_x <= mn_x) && (mx_y <= mn_y);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      valid_mem[wr_addr] <= wr_bit;
    end
    if (rect_we) begin
      rect_mem[wr_addr] <= q_rect;
    end
    rd_valid <= valid_mem[scan_idx];
    rd_rect  <= rect_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur      <= job;
      cur_slot <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_idx <= '0;
      count    <= '0;
      rd_pend  <= 1'b0;
    end else begin
      rd_pend <= (state == S_SCAN);
      if (rd_pend && hit && (count != COUNT_MAX)) begin
        count <= count + COUNT_W'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            count <= '0;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          scan_idx <= '0;
          priority if (cur.kind == CMD_QUERY) begin
            state <= (cur_slot == '0) ? S_DONE : S_SCAN;
          end else if (cur.kind == CMD_DELETE && cur.status == ST_OK) begin
            state <= S_DEL;
          end else begin
            state <= S_DONE;
          end
        end
        S_DEL: begin
          state <= S_DONE;
        end
        S_SCAN: begin
          if (scan_idx == last[AW-1:0]) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + AW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/rectangle_overlap_count_table_core.sv @@
// top level of the rectangle overlap count table
//
//   channel   handshake        payload
//   input     push / full      command, x_low, y_low, x_high, y_high, item_number
//   result    pop / empty      overlap_count, status
//
// a query scans, in the back end, the items seen before it (at most
// TABLE_DEPTH), one slot a cycle through the single read port of the
// rectangle store. other commands write the valid bit of their own slot, if
// they have one, and a delete then clears the slot it names. after reset the
// table is empty with no clearing pass. a two-entry queue parts front and back, another holds results.
`default_nettype none
module rectangle_overlap_count_table_core #(
  parameter int TABLE_DEPTH = 1024,
  parameter int COORD_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        command,
  input  logic [roct_pkg::IN_COORD_W-1:0]   x_low,
  input  logic [roct_pkg::IN_COORD_W-1:0]   y_low,
  input  logic [roct_pkg::IN_COORD_W-1:0]   x_high,
  input  logic [roct_pkg::IN_COORD_W-1:0]   y_high,
  input  logic [roct_pkg::NUM_W-1:0]        item_number,
  input  logic                              pop,
  output logic                              empty,
  output logic [roct_pkg::COUNT_W-1:0]      overlap_count,
  output logic [1:0]                        status
);
  import roct_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int JW    = $bits(job_t) + CNT_W;
  localparam int RSW   = $bits(result_t);

  logic             q_push;
  logic             q_full;
  job_t             q_job;
  logic [CNT_W-1:0] q_slot;
  logic [JW-1:0]    q_out;
  logic             q_empty;
  logic             job_pop;
  job_t             b_job;
  logic [CNT_W-1:0] b_slot;
  logic             res_push;
  logic             res_full;
  result_t          res_in;
  logic [RSW-1:0]   res_out;
  result_t          res_q;

  roct_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .x_low      (x_low),
    .y_low      (y_low),
    .x_high     (x_high),
    .y_high     (y_high),
    .item_number(item_number),
    .q_push     (q_push),
    .q_full     (q_full),
    .q_job      (q_job),
    .q_slot     (q_slot)
  );

  roct_fifo #(
    .WIDTH(JW)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .full    (q_full),
    .data_in ({q_slot, q_job}),
    .pop     (job_pop),
    .empty   (q_empty),
    .data_out(q_out)
  );

  assign {b_slot, b_job} = q_out;

  roct_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(!q_empty),
    .job_pop  (job_pop),
    .job      (b_job),
    .slot     (b_slot),
    .res_push (res_push),
    .res_full (res_full),
    .res      (res_in)
  );

  roct_fifo #(
    .WIDTH(RSW)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .full    (res_full),
    .data_in (res_in),
    .pop     (pop),
    .empty   (empty),
    .data_out(res_out)
  );

  assign res_q         = result_t'(res_out);
  assign overlap_count = res_q.count;
  assign status        = res_q.status;

endmodule
`default_nettype wire

@@ rtl/roct_checker.sv @@
// port-level checks for the rectangle overlap count table and their binding
`default_nettype none
module roct_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         push,
  input logic                         full,
  input logic                         pop,
  input logic                         empty,
  input logic [roct_pkg::COUNT_W-1:0] overlap_count,
  input logic [1:0]                   status
);
  import roct_pkg::*;

  logic [7:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  // items taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 8'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 8'd1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("results shown right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pending != 8'd0))
    else $error("result shown with no item outstanding");

  a_error_zero_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |-> (overlap_count == '0))
    else $error("nonzero count with an error status");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(overlap_count) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind rectangle_overlap_count_table_core roct_checker u_roct_checker (
  .clk          (clk),
  .rst          (rst),
  .push         (push),
  .full         (full),
  .pop          (pop),
  .empty        (empty),
  .overlap_count(overlap_count),
  .status       (status)
);
`default_nettype wire

@@ tb/roct_result_checker.sv @@
// result checker for the rectangle overlap count table: predicts each result and compares
`timescale 1ns / 100ps
module roct_result_checker #(
  parameter int TABLE_DEPTH = 1024,
  parameter int COORD_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  logic [1:0]                      command,
  input  logic [roct_pkg::IN_COORD_W-1:0] x_low,
  input  logic [roct_pkg::IN_COORD_W-1:0] y_low,
  input  logic [roct_pkg::IN_COORD_W-1:0] x_high,
  input  logic [roct_pkg::IN_COORD_W-1:0] y_high,
  input  logic [roct_pkg::NUM_W-1:0]      item_number,
  input  logic                            pop,
  input  logic                            empty,
  input  logic [roct_pkg::COUNT_W-1:0]    overlap_count,
  input  logic [1:0]                      status,
  output int                              mismatches,
  output int                              awaited_count
);
  import roct_pkg::*;

  result_t     awaited_results[$];
  result_t     oldest;
  result_t     predicted;
  int          items_seen;
  logic        slot_live [TABLE_DEPTH];
  logic [31:0] box_xl [TABLE_DEPTH];
  logic [31:0] box_yl [TABLE_DEPTH];
  logic [31:0] box_xh [TABLE_DEPTH];
  logic [31:0] box_yh [TABLE_DEPTH];

  function automatic logic [31:0] coord_of(logic [IN_COORD_W-1:0] v);
    logic [31:0] mask;
    mask = (COORD_BITS >= 32) ? 32'hffff_ffff : ((32'd1 << COORD_BITS) - 32'd1);
    return 32'(v) & mask;
  endfunction

  function automatic bit axis_meets(logic [31:0] lo_a, logic [31:0] hi_a,
                                    logic [31:0] lo_b, logic [31:0] hi_b);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = (lo_a > lo_b) ? lo_a : lo_b;
    hi = (hi_a < hi_b) ? hi_a : hi_b;
    return lo <= hi;
  endfunction

  function automatic result_t apply_command(logic [1:0] cmd, logic [31:0] xl, logic [31:0] yl,
                                            logic [31:0] xh, logic [31:0] yh,
                                            logic [NUM_W-1:0] num);
    result_t res;
    res.count  = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_QUERY: begin
        for (int j = 0; j < TABLE_DEPTH; j++) begin
          if (slot_live[j] && axis_meets(xl, xh, box_xl[j], box_xh[j])
              && axis_meets(yl, yh, box_yl[j], box_yh[j]) && res.count != COUNT_MAX) begin
            res.count = res.count + 1'b1;
          end
        end
      end
      CMD_INSERT: begin
        if (items_seen < TABLE_DEPTH) begin
          box_xl[items_seen]    = xl;
          box_yl[items_seen]    = yl;
          box_xh[items_seen]    = xh;
          box_yh[items_seen]    = yh;
          slot_live[items_seen] = 1'b1;
        end else begin
          res.status = ST_FULL;
        end
      end
      CMD_DELETE: begin
        if (num >= 1 && num <= TABLE_DEPTH) begin
          slot_live[num - 1] = 1'b0;
        end else begin
          res.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    if (items_seen < TABLE_DEPTH) items_seen++;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      items_seen = 0;
      mismatches = 0;
      for (int j = 0; j < TABLE_DEPTH; j++) slot_live[j] = 1'b0;
      awaited_results.delete();
    end else begin
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: overlap_count %0d status %0d with nothing awaited",
                 overlap_count, status);
          mismatches++;
        end else begin
          oldest = awaited_results.pop_front();
          if (overlap_count !== oldest.count) begin
            $error("overlap_count mismatch: expected %0d, actual %0d", oldest.count,
                   overlap_count);
            mismatches++;
          end
          if (status !== oldest.status) begin
            $error("status mismatch: expected %0d, actual %0d", oldest.status, status);
            mismatches++;
          end
        end
      end
      if (push && !full) begin
        predicted = apply_command(command, coord_of(x_low), coord_of(y_low),
                                  coord_of(x_high), coord_of(y_high), item_number);
        awaited_results = {awaited_results, predicted};
      end
    end
    awaited_count = awaited_results.size();
  end

endmodule

@@ tb/tb_rectangle_overlap_count_table_core.sv @@
// testbench top for the rectangle overlap count table: stimulus, idling, watchdog and verdict
`timescale 1ns / 100ps
module tb_rectangle_overlap_count_table_core;
  import roct_pkg::*;

  localparam int         TABLE_DEPTH  = 1024;
  localparam int         COORD_BITS   = 16;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 557;
  localparam int         HOLD_AFTER   = 150;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         DRAIN_CYCLES = 1100;
  localparam int         STALL_LIMIT  = 12000;

  typedef struct {
    logic [IN_COORD_W-1:0] xl;
    logic [IN_COORD_W-1:0] yl;
    logic [IN_COORD_W-1:0] xh;
    logic [IN_COORD_W-1:0] yh;
  } box_t;

  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  push        = 1'b0;
  logic                  pop         = 1'b0;
  logic [1:0]            command     = '0;
  logic [IN_COORD_W-1:0] x_low       = '0;
  logic [IN_COORD_W-1:0] y_low       = '0;
  logic [IN_COORD_W-1:0] x_high      = '0;
  logic [IN_COORD_W-1:0] y_high      = '0;
  logic [NUM_W-1:0]      item_number = '0;
  logic                  full;
  logic                  empty;
  logic [COUNT_W-1:0]    overlap_count;
  logic [1:0]            status;

  int mismatches;
  int awaited_count;
  int sent_count    = 0;
  int results_taken = 0;
  int idle_cycles   = 0;
  int hold_left     = 0;
  int stall_left    = 0;
  bit hold_done     = 1'b0;
  bit calm          = 1'b0;
  int insert_numbers[$];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  rectangle_overlap_count_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .command      (command),
    .x_low        (x_low),
    .y_low        (y_low),
    .x_high       (x_high),
    .y_high       (y_high),
    .item_number  (item_number),
    .pop          (pop),
    .empty        (empty),
    .overlap_count(overlap_count),
    .status       (status)
  );

  roct_result_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .command      (command),
    .x_low        (x_low),
    .y_low        (y_low),
    .x_high       (x_high),
    .y_high       (y_high),
    .item_number  (item_number),
    .pop          (pop),
    .empty        (empty),
    .overlap_count(overlap_count),
    .status       (status),
    .mismatches   (mismatches),
    .awaited_count(awaited_count)
  );

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  function automatic box_t make_box(logic [IN_COORD_W-1:0] xl, logic [IN_COORD_W-1:0] yl,
                                    logic [IN_COORD_W-1:0] xh, logic [IN_COORD_W-1:0] yh);
    box_t b;
    b.xl = xl;
    b.yl = yl;
    b.xh = xh;
    b.yh = yh;
    return b;
  endfunction

  function automatic box_t noise_box();
    return make_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  function automatic box_t random_box(int span);
    box_t                  b;
    int                    mode;
    logic [IN_COORD_W-1:0] t;
    mode = $urandom_range(0, 99);
    b.xl = 16'($urandom_range(0, 1023));
    b.yl = 16'($urandom_range(0, 1023));
    b.xh = b.xl + 16'($urandom_range(0, span));
    b.yh = b.yl + 16'($urandom_range(0, span));
    if (mode >= 75 && mode < 87) begin
      b = noise_box();
    end else if (mode >= 87 && mode < 95) begin
      if ($urandom_range(0, 1) == 1) begin
        t    = b.xl;
        b.xl = b.xh + 1'b1;
        b.xh = t;
      end else begin
        t    = b.yl;
        b.yl = b.yh + 1'b1;
        b.yh = t;
      end
    end else if (mode >= 95) begin
      b.xh = '1;
      b.yl = '0;
    end
    return b;
  endfunction

  function automatic logic [NUM_W-1:0] noise_num();
    return 11'($urandom_range(0, 2047));
  endfunction

  function automatic logic [NUM_W-1:0] delete_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80 && insert_numbers.size() > 0)
      return 11'(insert_numbers[$urandom_range(0, insert_numbers.size() - 1)]);
    if (r < 90) return 11'($urandom_range(1, TABLE_DEPTH));
    return 11'($urandom_range(0, 2047));
  endfunction

  task automatic drive_item(input logic [1:0] cmd, input box_t b, input logic [NUM_W-1:0] num);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push        <= 1'b1;
    command     <= cmd;
    x_low       <= b.xl;
    y_low       <= b.yl;
    x_high      <= b.xh;
    y_high      <= b.yh;
    item_number <= num;
    @(posedge clk);
    while (full) @(posedge clk);
    sent_count++;
    if (cmd == CMD_INSERT) insert_numbers = {insert_numbers, sent_count};
    @(negedge clk);
  endtask

  task automatic random_item(input int insert_pct, input int query_pct, input int delete_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < insert_pct) begin
      drive_item(CMD_INSERT, random_box(160), noise_num());
    end else if (pick < insert_pct + query_pct) begin
      drive_item(CMD_QUERY, random_box(400), noise_num());
    end else if (pick < insert_pct + query_pct + delete_pct) begin
      drive_item(CMD_DELETE, noise_box(), delete_target());
    end else begin
      drive_item(CMD_UNUSED, noise_box(), noise_num());
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (!hold_done && results_taken >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      stall_left = idle_len();
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (pop && !empty) results_taken++;
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table, corner rectangles, inclusive edges, inverted boxes, delete ranges and the unused command
    drive_item(CMD_QUERY, make_box(16'h0000, 16'h0000, 16'hffff, 16'hffff), 11'h7ff);
    drive_item(CMD_INSERT, make_box(16'h0000, 16'h0000, 16'h0000, 16'h0000), 11'h000);
    drive_item(CMD_INSERT, make_box(16'hffff, 16'hffff, 16'hffff, 16'hffff), 11'h7ff);
    drive_item(CMD_INSERT, make_box(16'h0000, 16'h0000, 16'hffff, 16'hffff), 11'h555);
    drive_item(CMD_INSERT, make_box(16'h0064, 16'h0064, 16'h0032, 16'h0032), 11'h2aa);
    drive_item(CMD_INSERT, make_box(16'h000a, 16'h0014, 16'h001e, 16'h0028), 11'h001);
    drive_item(CMD_INSERT, make_box(16'haaaa, 16'h5555, 16'haaab, 16'h5556), 11'h400);
    drive_item(CMD_QUERY, make_box(16'h0000, 16'h0000, 16'hffff, 16'hffff), 11'h000);
    drive_item(CMD_QUERY, make_box(16'h0000, 16'h0000, 16'h0000, 16'h0000), 11'h000);
    drive_item(CMD_QUERY, make_box(16'hffff, 16'hffff, 16'h0000, 16'h0000), 11'h000);
    drive_item(CMD_QUERY, make_box(16'h001e, 16'h0028, 16'h001e, 16'h0028), 11'h000);
    drive_item(CMD_QUERY, make_box(16'h001f, 16'h0029, 16'h0032, 16'h0032), 11'h000);
    drive_item(CMD_QUERY, make_box(16'h5555, 16'haaaa, 16'haaab, 16'h5556), 11'h000);
    drive_item(CMD_DELETE, make_box(16'hffff, 16'hffff, 16'hffff, 16'hffff), 11'd2);
    drive_item(CMD_DELETE, make_box(16'h0000, 16'h0000, 16'h0000, 16'h0000), 11'd2);
    drive_item(CMD_DELETE, make_box(16'h0000, 16'h0000, 16'h0000, 16'h0000), 11'd1);
    drive_item(CMD_DELETE, make_box(16'h0000, 16'h0000, 16'h0000, 16'h0000), 11'd1000);
    drive_item(CMD_DELETE, make_box(16'h0000, 16'h0000, 16'h0000, 16'h0000), 11'd0);
    drive_item(CMD_DELETE, make_box(16'h0000, 16'h0000, 16'h0000, 16'h0000), 11'd1024);
    drive_item(CMD_DELETE, make_box(16'h0000, 16'h0000, 16'h0000, 16'h0000), 11'd1025);
    drive_item(CMD_DELETE, make_box(16'h0000, 16'h0000, 16'h0000, 16'h0000), 11'd2047);
    drive_item(CMD_UNUSED, make_box(16'hffff, 16'hffff, 16'hffff, 16'hffff), 11'h7ff);
    drive_item(CMD_QUERY, make_box(16'h0000, 16'h0000, 16'hffff, 16'hffff), 11'h7ff);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 250 && i < 330);
      random_item(35, 30, 25);
    end
    calm = 1'b0;

    push <= 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/roct_pkg.sv
rtl/roct_fifo.sv
rtl/roct_front.sv
rtl/roct_back.sv
rtl/rectangle_overlap_count_table_core.sv
rtl/roct_checker.sv
tb/roct_result_checker.sv
tb/tb_rectangle_overlap_count_table_core.sv
